@@ hdl/obb_obb_overlap_test_core_assert.svh @@
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_core_assert.svh
// assertion macros shared by the box overlap checkers
// ----------------------------------------------------------------------------
`ifndef OBB_OBB_OVERLAP_TEST_CORE_ASSERT_SVH
`define OBB_OBB_OVERLAP_TEST_CORE_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define OBB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, always enabled
`define OBB_ASSERT_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/obb_pkg.sv @@
// ----------------------------------------------------------------------------
// obb_pkg
// shared constants of the oriented box overlap test
// ----------------------------------------------------------------------------
package obb_pkg;

   // extra root bits: the squared length is scaled by 2^(2*NORM_EXTRA_BITS)
   localparam int NORM_EXTRA_BITS = 10;

endpackage

@@ hdl/obb_norm.sv @@
// ----------------------------------------------------------------------------
// obb_norm
// pipelined row normalizer: squared length, bit-serial square root, then a
// restoring divide per component, one row per clock
// ----------------------------------------------------------------------------
module obb_norm #(
   parameter int COMPONENT_BITS       = 21,
   parameter int MATRIX_FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic [2:0][COMPONENT_BITS-1:0]          comp_in,
   output logic [2:0][MATRIX_FRACTION_BITS+1:0]    axis_out
);

   localparam int CB  = COMPONENT_BITS;
   localparam int F   = MATRIX_FRACTION_BITS;
   localparam int EB  = obb_pkg::NORM_EXTRA_BITS;
   localparam int NB  = CB + EB;       // root width
   localparam int XW  = 2 * NB;        // radicand width
   localparam int RW  = NB + 2;        // partial remainder width
   localparam int SW  = 2 * CB;        // squared length width
   localparam int DW  = NB + F;        // dividend width
   localparam int QW  = F + 1;         // quotient width
   localparam int UW  = F + 2;         // unit axis width

   // squares
   logic [SW-2:0]              sq_ff    [3];
   logic [2:0][CB-1:0]         mag0_ff;
   logic [2:0]                 neg0_ff;

   // square root stages
   logic [XW-1:0]              x_ff     [NB+1];
   logic [RW-1:0]              r_ff     [NB+1];
   logic [NB-1:0]              rt_ff    [NB+1];
   logic [2:0][CB-1:0]         magq_ff  [NB+1];
   logic [2:0]                 negq_ff  [NB+1];

   // divide stages
   logic [DW-1:0]              rem_ff   [QW+1][3];
   logic [QW-1:0]              quo_ff   [QW+1][3];
   logic [NB-1:0]              dn_ff    [QW+1];
   logic [2:0]                 negd_ff  [QW+1];

   logic [2:0][UW-1:0]         axis_ff;

   logic signed [SW-1:0]       sq_full  [3];
   logic [SW-1:0]              s_sum;
   logic [RW-1:0]              trial    [NB];
   logic [NB-1:0]              take;
   logic [DW-1:0]              dsub     [QW][3];
   logic                       dtake    [QW][3];
   logic [QW-1:0]              qclamp   [3];

   localparam logic [QW-1:0]   ONE = QW'(1) << F;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_full[k] = SW'($signed(comp_in[k])) * SW'($signed(comp_in[k]));
      end
      s_sum = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      for (int k = 0; k < NB; k++) begin
         trial[k] = {r_ff[k][RW-3:0], x_ff[k][XW-1 -: 2]};
         take[k]  = trial[k] >= {rt_ff[k], 2'b01};
      end
      for (int j = 0; j < QW; j++) begin
         for (int k = 0; k < 3; k++) begin
            dsub[j][k]  = DW'(dn_ff[j]) << (F - j);
            dtake[j][k] = rem_ff[j][k] >= dsub[j][k];
         end
      end
      for (int k = 0; k < 3; k++) begin
         qclamp[k] = (quo_ff[QW][k] > ONE) ? ONE : quo_ff[QW][k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         sq_ff[k]   <= sq_full[k][SW-2:0];
         mag0_ff[k] <= comp_in[k][CB-1] ? CB'(-comp_in[k]) : comp_in[k];
         neg0_ff[k] <= comp_in[k][CB-1];
      end

      x_ff[0]    <= XW'(s_sum) << (2 * EB);
      r_ff[0]    <= '0;
      rt_ff[0]   <= '0;
      magq_ff[0] <= mag0_ff;
      negq_ff[0] <= neg0_ff;
      for (int k = 0; k < NB; k++) begin
         x_ff[k+1]    <= x_ff[k] << 2;
         r_ff[k+1]    <= take[k] ? (trial[k] - {rt_ff[k], 2'b01}) : trial[k];
         rt_ff[k+1]   <= {rt_ff[k][NB-2:0], take[k]};
         magq_ff[k+1] <= magq_ff[k];
         negq_ff[k+1] <= negq_ff[k];
      end

      dn_ff[0]   <= rt_ff[NB];
      negd_ff[0] <= negq_ff[NB];
      for (int k = 0; k < 3; k++) begin
         rem_ff[0][k] <= DW'(magq_ff[NB][k]) << (F + EB);
         quo_ff[0][k] <= '0;
      end
      for (int j = 0; j < QW; j++) begin
         dn_ff[j+1]   <= dn_ff[j];
         negd_ff[j+1] <= negd_ff[j];
         for (int k = 0; k < 3; k++) begin
            rem_ff[j+1][k] <= dtake[j][k] ? (rem_ff[j][k] - dsub[j][k]) : rem_ff[j][k];
            quo_ff[j+1][k] <= {quo_ff[j][k][QW-2:0], dtake[j][k]};
         end
      end

      // zero row gives a zero axis
      for (int k = 0; k < 3; k++) begin
         if (dn_ff[QW] == '0) begin
            axis_ff[k] <= '0;
         end else if (negd_ff[QW][k]) begin
            axis_ff[k] <= -UW'(qclamp[k]);
         end else begin
            axis_ff[k] <= UW'(qclamp[k]);
         end
      end
   end

   assign axis_out = axis_ff;

endmodule

@@ hdl/obb_obb_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_core
// oriented box pair overlap test, 15-axis separating axis test
// ----------------------------------------------------------------------------
// A box pair is taken on any clock where start is high and busy is low, one
// pair per clock with no gaps needed. Each transaction returns one hit bit
// on rsp_hit, strobed by rsp_valid for a single cycle. Most of the pipeline
// depth lies in the row normalizer: a square root that settles one root bit
// per stage (COMPONENT_BITS + 10 stages) followed by a divider producing
// one quotient bit per stage (MATRIX_FRACTION_BITS + 1 stages). The
// receiver cannot stall results, so every strobe must be captured; busy is
// high only during reset.
// ----------------------------------------------------------------------------
module obb_obb_overlap_test_core #(
   parameter int COMPONENT_BITS       = 21,
   parameter int MATRIX_FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_a_center,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_a_half_extent,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_a_row_x,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_a_row_y,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_a_row_z,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_b_center,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_b_half_extent,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_b_row_x,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_b_row_y,
   input  logic [3*COMPONENT_BITS-1:0]   req_box_b_row_z,
   output logic                          rsp_valid,
   output logic                          rsp_hit
);

   localparam int CB        = COMPONENT_BITS;
   localparam int F         = MATRIX_FRACTION_BITS;
   localparam int NORM_LAT  = CB + obb_pkg::NORM_EXTRA_BITS + F + 5;
   localparam int TOTAL_LAT = NORM_LAT + 7;
   localparam int VW        = CB + 1;       // center difference
   localparam int UW        = F + 2;        // unit axis
   localparam int UUW       = 2 * F + 4;    // axis product
   localparam int DRW       = 2 * F + 6;    // axis dot
   localparam int VUW       = CB + F + 3;   // offset product
   localparam int DTW       = CB + F + 5;   // offset dot
   localparam int RW        = F + 3;        // rotation entry
   localparam int TW        = CB + 3;       // projected offset
   localparam int PRW       = CB + F + 6;   // test products
   localparam int SW        = CB + F + 9;   // test sums

   logic [2:0][CB-1:0] a_cen_w, b_cen_w, a_ext_w, b_ext_w;
   logic [5:0][2:0][CB-1:0] row_w;

   assign a_cen_w  = req_box_a_center;
   assign b_cen_w  = req_box_b_center;
   assign a_ext_w  = req_box_a_half_extent;
   assign b_ext_w  = req_box_b_half_extent;
   assign row_w[0] = req_box_a_row_x;
   assign row_w[1] = req_box_a_row_y;
   assign row_w[2] = req_box_a_row_z;
   assign row_w[3] = req_box_b_row_x;
   assign row_w[4] = req_box_b_row_y;
   assign row_w[5] = req_box_b_row_z;

   // control
   logic                   s0_vld_ff;
   logic [NORM_LAT-1:0]    dl_vld_ff;
   logic [5:0]             p_vld_ff;

   // input stage
   logic [2:0][VW-1:0]     s0_v_ff;
   logic [2:0][CB-1:0]     s0_ea_ff, s0_eb_ff;
   logic [5:0][2:0][CB-1:0] s0_row_ff;

   // side data waits for the normalizers
   logic [2:0][VW-1:0]     dl_v_ff  [NORM_LAT];
   logic [2:0][CB-1:0]     dl_ea_ff [NORM_LAT];
   logic [2:0][CB-1:0]     dl_eb_ff [NORM_LAT];

   logic [5:0][2:0][UW-1:0] axis_w;

   logic [2:0][CB-1:0]     ea_p_ff [4];
   logic [2:0][CB-1:0]     eb_p_ff [4];

   logic signed [UUW-1:0]  uu_ff  [3][3][3];
   logic signed [VUW-1:0]  vu_ff  [3][3];
   logic signed [DRW-1:0]  dr_ff  [3][3];
   logic signed [DTW-1:0]  dt_ff  [3];
   logic signed [RW-1:0]   r_ff   [3][3];
   logic signed [RW-1:0]   ar_ff  [3][3];
   logic signed [TW-1:0]   t_ff   [3];
   logic signed [TW-1:0]   t4_ff  [3];
   logic signed [PRW-1:0]  ear_ff [3][3][3];
   logic signed [PRW-1:0]  ebr_ff [3][3][3];
   logic signed [PRW-1:0]  tr_ff  [3][3][3];
   logic signed [SW-1:0]   tv_ff  [15];
   logic signed [SW-1:0]   rad_ff [15];
   logic                   rsp_hit_ff;

   // rounding and test sums
   logic [DRW-1:0]         dr_mag  [3][3];
   logic [DRW-1:0]         dr_rnd  [3][3];
   logic [DTW-1:0]         dt_mag  [3];
   logic [DTW-1:0]         dt_rnd  [3];
   logic signed [SW-1:0]   tv_c    [15];
   logic signed [SW-1:0]   rad_c   [15];
   logic [14:0]            sep;

   assign busy = reset;

   genvar g;
   generate
      for (g = 0; g < 6; g++) begin : g_norm
         obb_norm #(
            .COMPONENT_BITS       (CB),
            .MATRIX_FRACTION_BITS (F)
         ) u_norm (
            .clock    (clock),
            .comp_in  (s0_row_ff[g]),
            .axis_out (axis_w[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         dl_vld_ff <= '0;
         p_vld_ff  <= '0;
      end else begin
         s0_vld_ff <= start && !busy;
         dl_vld_ff <= {dl_vld_ff[NORM_LAT-2:0], s0_vld_ff};
         p_vld_ff  <= {p_vld_ff[4:0], dl_vld_ff[NORM_LAT-1]};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dr_mag[i][j] = dr_ff[i][j][DRW-1] ? DRW'(-dr_ff[i][j]) : DRW'(dr_ff[i][j]);
            dr_rnd[i][j] = (dr_mag[i][j] + (DRW'(1) << (F - 1))) >> F;
         end
         dt_mag[i] = dt_ff[i][DTW-1] ? DTW'(-dt_ff[i]) : DTW'(dt_ff[i]);
         dt_rnd[i] = (dt_mag[i] + (DTW'(1) << (F - 1))) >> F;
      end
   end

   always_comb begin
      int i1, i2, j1, j2, ax;
      logic signed [SW-1:0] tt;
      for (int i = 0; i < 3; i++) begin
         // face axes of A
         tt = SW'(t4_ff[i]);
         tv_c[i]  = ((tt < 0) ? -tt : tt) <<< F;
         rad_c[i] = (SW'($signed(ea_p_ff[3][i])) <<< F) + SW'(ebr_ff[0][i][0])
                  + SW'(ebr_ff[1][i][1]) + SW'(ebr_ff[2][i][2]);
         // face axes of B
         tt = SW'(tr_ff[0][0][i]) + SW'(tr_ff[1][1][i]) + SW'(tr_ff[2][2][i]);
         tv_c[3+i]  = (tt < 0) ? -tt : tt;
         rad_c[3+i] = (SW'($signed(eb_p_ff[3][i])) <<< F) + SW'(ear_ff[0][0][i])
                    + SW'(ear_ff[1][1][i]) + SW'(ear_ff[2][2][i]);
      end
      // edge cross products
      for (int i = 0; i < 3; i++) begin
         i1 = (i == 2) ? 0 : i + 1;
         i2 = (i == 0) ? 2 : i - 1;
         for (int j = 0; j < 3; j++) begin
            j1 = (j == 2) ? 0 : j + 1;
            j2 = (j == 0) ? 2 : j - 1;
            ax = 6 + 3 * i + j;
            tt = SW'(tr_ff[i2][i1][j]) - SW'(tr_ff[i1][i2][j]);
            tv_c[ax]  = (tt < 0) ? -tt : tt;
            rad_c[ax] = SW'(ear_ff[i1][i2][j]) + SW'(ear_ff[i2][i1][j])
                      + SW'(ebr_ff[j1][i][j2]) + SW'(ebr_ff[j2][i][j1]);
         end
      end
      for (int a = 0; a < 15; a++) begin
         sep[a] = tv_ff[a] > rad_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      // input stage
      for (int k = 0; k < 3; k++) begin
         s0_v_ff[k] <= VW'($signed(b_cen_w[k])) - VW'($signed(a_cen_w[k]));
      end
      s0_ea_ff  <= a_ext_w;
      s0_eb_ff  <= b_ext_w;
      s0_row_ff <= row_w;

      dl_v_ff[0]  <= s0_v_ff;
      dl_ea_ff[0] <= s0_ea_ff;
      dl_eb_ff[0] <= s0_eb_ff;
      for (int d = 1; d < NORM_LAT; d++) begin
         dl_v_ff[d]  <= dl_v_ff[d-1];
         dl_ea_ff[d] <= dl_ea_ff[d-1];
         dl_eb_ff[d] <= dl_eb_ff[d-1];
      end

      // axis products
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               uu_ff[i][j][k] <= UUW'($signed(axis_w[i][k])) * UUW'($signed(axis_w[3+j][k]));
            end
            vu_ff[i][k] <= VUW'($signed(dl_v_ff[NORM_LAT-1][k]))
                         * VUW'($signed(axis_w[i][k]));
         end
      end
      ea_p_ff[0] <= dl_ea_ff[NORM_LAT-1];
      eb_p_ff[0] <= dl_eb_ff[NORM_LAT-1];
      for (int s = 1; s < 4; s++) begin
         ea_p_ff[s] <= ea_p_ff[s-1];
         eb_p_ff[s] <= eb_p_ff[s-1];
      end

      // dots
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dr_ff[i][j] <= DRW'(uu_ff[i][j][0]) + DRW'(uu_ff[i][j][1]) + DRW'(uu_ff[i][j][2]);
         end
         dt_ff[i] <= DTW'(vu_ff[i][0]) + DTW'(vu_ff[i][1]) + DTW'(vu_ff[i][2]);
      end

      // round half away from zero
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r_ff[i][j]  <= dr_ff[i][j][DRW-1] ? -RW'(dr_rnd[i][j]) : RW'(dr_rnd[i][j]);
            ar_ff[i][j] <= RW'(dr_rnd[i][j]);
         end
         t_ff[i] <= dt_ff[i][DTW-1] ? -TW'(dt_rnd[i]) : TW'(dt_rnd[i]);
      end

      // radius and projection products
      for (int a = 0; a < 3; a++) begin
         t4_ff[a] <= t_ff[a];
         for (int b = 0; b < 3; b++) begin
            for (int j = 0; j < 3; j++) begin
               ear_ff[a][b][j] <= PRW'($signed(ea_p_ff[2][a])) * PRW'(ar_ff[b][j]);
               ebr_ff[a][b][j] <= PRW'($signed(eb_p_ff[2][a])) * PRW'(ar_ff[b][j]);
               tr_ff[a][b][j]  <= PRW'(t_ff[a]) * PRW'(r_ff[b][j]);
            end
         end
      end

      // per-axis sums
      for (int a = 0; a < 15; a++) begin
         tv_ff[a]  <= tv_c[a];
         rad_ff[a] <= rad_c[a];
      end

      rsp_hit_ff <= (sep == '0);
   end

   assign rsp_valid = p_vld_ff[5];
   assign rsp_hit   = rsp_hit_ff;

endmodule

@@ hdl/obb_chk.sv @@
// ----------------------------------------------------------------------------
// obb_chk
// port-level checks for the box overlap core, bound to the top level
// ----------------------------------------------------------------------------
`include "obb_obb_overlap_test_core_assert.svh"

module obb_chk #(
   parameter int LATENCY = 59
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   `OBB_ASSERT_IMP(a_busy_only_in_reset, clock, reset, 1'b1, !busy, "busy outside reset")

   `OBB_ASSERT_NXT(a_reset_clears_strobe, clock, reset, !rsp_valid, "result strobe after reset")

   `OBB_ASSERT_IMP(a_fixed_latency, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result without matching transaction")

endmodule

bind obb_obb_overlap_test_core obb_chk #(.LATENCY(TOTAL_LAT)) u_obb_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

@@ tb/sv/obb_obb_overlap_test_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_core_tb
// drives box pairs into the overlap core and checks each hit bit against a
// bit-exact fixed-point separating axis predictor kept in the bench
// ----------------------------------------------------------------------------
module obb_obb_overlap_test_core_tb;

   localparam int CB = 21;
   localparam int MF = 16;
   localparam int W = 3 * CB;
   localparam int LATENCY = CB + MF + 22;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic [W-1:0] vec_type;
   typedef struct {
      vec_type ctr_a, ext_a, ax, ay, az, ctr_b, ext_b, bx, by, bz;
   } box_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   vec_type req_box_a_center = '0, req_box_a_half_extent = '0;
   vec_type req_box_a_row_x = '0, req_box_a_row_y = '0, req_box_a_row_z = '0;
   vec_type req_box_b_center = '0, req_box_b_half_extent = '0;
   vec_type req_box_b_row_x = '0, req_box_b_row_y = '0, req_box_b_row_z = '0;
   logic rsp_valid;
   logic rsp_hit;

   bit expected_hits[$];
   int err_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;

   obb_obb_overlap_test_core #(.COMPONENT_BITS(CB), .MATRIX_FRACTION_BITS(MF)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_box_a_center(req_box_a_center), .req_box_a_half_extent(req_box_a_half_extent),
      .req_box_a_row_x(req_box_a_row_x), .req_box_a_row_y(req_box_a_row_y),
      .req_box_a_row_z(req_box_a_row_z), .req_box_b_center(req_box_b_center),
      .req_box_b_half_extent(req_box_b_half_extent), .req_box_b_row_x(req_box_b_row_x),
      .req_box_b_row_y(req_box_b_row_y), .req_box_b_row_z(req_box_b_row_z),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit)
   );

   always #5 clock = ~clock;

   function automatic longint comp(vec_type w, int k);
      logic signed [CB-1:0] c;
      c = w[k*CB +: CB];
      return longint'(c);
   endfunction

   function automatic longint sq_root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint mag(longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic longint round_off(longint x);
      longint r;
      r = (mag(x) + (64'sd1 <<< (MF - 1))) >>> MF;
      return x < 0 ? -r : r;
   endfunction

   // normalize one matrix row to a unit axis, zero row gives zero axis
   function automatic void unit_axis(vec_type row, output longint u[3]);
      longint c[3];
      longint unsigned s, n, q;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         c[k] = comp(row, k);
         s += longint'(c[k] * c[k]);
      end
      n = sq_root(s << 20);
      for (int k = 0; k < 3; k++) begin
         if (n == 0) begin
            u[k] = 0;
         end else begin
            q = (longint'(mag(c[k])) << (MF + 10)) / n;
            if (q > (64'd1 << MF)) q = 64'd1 << MF;
            u[k] = c[k] < 0 ? -longint'(q) : longint'(q);
         end
      end
   endfunction

   function automatic bit boxes_overlap(box_pair_type p);
      longint ua[3][3], ub[3][3], r[3][3], ar[3][3], t[3], ea[3], eb[3], d[3], u[3];
      longint sc, rad, tv, ra, rb;
      bit hit;
      int i1, i2, j1, j2;
      sc = 64'sd1 <<< MF;
      hit = 1;
      unit_axis(p.ax, u); ua[0] = u;
      unit_axis(p.ay, u); ua[1] = u;
      unit_axis(p.az, u); ua[2] = u;
      unit_axis(p.bx, u); ub[0] = u;
      unit_axis(p.by, u); ub[1] = u;
      unit_axis(p.bz, u); ub[2] = u;
      for (int k = 0; k < 3; k++) begin
         d[k] = comp(p.ctr_b, k) - comp(p.ctr_a, k);
         ea[k] = comp(p.ext_a, k);
         eb[k] = comp(p.ext_b, k);
      end
      for (int i = 0; i < 3; i++) begin
         t[i] = round_off(d[0]*ua[i][0] + d[1]*ua[i][1] + d[2]*ua[i][2]);
         for (int j = 0; j < 3; j++) begin
            r[i][j] = round_off(ua[i][0]*ub[j][0] + ua[i][1]*ub[j][1] + ua[i][2]*ub[j][2]);
            ar[i][j] = mag(r[i][j]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         rad = ea[i]*sc + eb[0]*ar[i][0] + eb[1]*ar[i][1] + eb[2]*ar[i][2];
         if (mag(t[i]) * sc > rad) hit = 0;
      end
      for (int j = 0; j < 3; j++) begin
         rad = eb[j]*sc + ea[0]*ar[0][j] + ea[1]*ar[1][j] + ea[2]*ar[2][j];
         tv = t[0]*r[0][j] + t[1]*r[1][j] + t[2]*r[2][j];
         if (mag(tv) > rad) hit = 0;
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            ra = ea[i1]*ar[i2][j] + ea[i2]*ar[i1][j];
            rb = eb[j1]*ar[i][j2] + eb[j2]*ar[i][j1];
            tv = t[i2]*r[i1][j] - t[i1]*r[i2][j];
            if (mag(tv) > ra + rb) hit = 0;
         end
      end
      return hit;
   endfunction

   function automatic vec_type pack3(longint x, longint y, longint z);
      return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
   endfunction

   function automatic vec_type rand_vec();
      return W'({$urandom, $urandom});
   endfunction

   // small signed value in a random range so many pairs land near contact
   function automatic longint rand_comp(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   // send one pair; start stays high across back-to-back transactions
   task automatic send_pair(box_pair_type p);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_box_a_center <= p.ctr_a; req_box_a_half_extent <= p.ext_a;
      req_box_a_row_x <= p.ax; req_box_a_row_y <= p.ay; req_box_a_row_z <= p.az;
      req_box_b_center <= p.ctr_b; req_box_b_half_extent <= p.ext_b;
      req_box_b_row_x <= p.bx; req_box_b_row_y <= p.by; req_box_b_row_z <= p.bz;
      do @(posedge clock); while (busy);
      expected_hits.push_back(boxes_overlap(p));
   endtask

   task automatic finish_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic box_pair_type aligned_pair(longint sep, longint ext);
      box_pair_type p;
      longint one;
      one = 64'sd1 <<< MF;
      p.ctr_a = '0;
      p.ctr_b = pack3(sep, 0, 0);
      p.ext_a = pack3(ext, ext, ext);
      p.ext_b = pack3(ext, ext, ext);
      p.ax = pack3(one, 0, 0); p.ay = pack3(0, one, 0); p.az = pack3(0, 0, one);
      p.bx = p.ax; p.by = p.ay; p.bz = p.az;
      return p;
   endfunction

   task automatic test_directed();
      box_pair_type p;
      vec_type ones, minv, maxv;
      ones = {W{1'b1}};
      minv = {3{1'b1, {(CB-1){1'b0}}}};
      maxv = {3{1'b0, {(CB-1){1'b1}}}};
      // touching faces, just apart, just overlapping
      send_pair(aligned_pair(512, 256));
      send_pair(aligned_pair(513, 256));
      send_pair(aligned_pair(511, 256));
      send_pair(aligned_pair(-513, 256));
      // zero rows on both boxes
      p = aligned_pair(100, 64);
      p.ax = '0; p.by = '0;
      send_pair(p);
      p = aligned_pair(0, 0);
      p.ax = '0; p.ay = '0; p.az = '0; p.bx = '0; p.by = '0; p.bz = '0;
      send_pair(p);
      // negative half extents
      p = aligned_pair(0, -10);
      send_pair(p);
      // non-orthogonal rows
      p = aligned_pair(300, 200);
      p.bx = pack3(1000, 1000, 0); p.by = pack3(1000, 1000, 0);
      send_pair(p);
      // field extremes
      p = '{ones, ones, ones, ones, ones, ones, ones, ones, ones, ones};
      send_pair(p);
      p = '{minv, maxv, minv, maxv, minv, maxv, minv, maxv, minv, maxv};
      send_pair(p);
      p = '{maxv, minv, maxv, minv, maxv, minv, maxv, minv, maxv, minv};
      send_pair(p);
      p = '{maxv, maxv, maxv, maxv, maxv, minv, maxv, minv, minv, minv};
      send_pair(p);
      p = '{default: '0};
      send_pair(p);
   endtask

   task automatic test_random(int count);
      box_pair_type p;
      int span;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 2) begin
            p = '{rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                  rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec()};
         end else begin
            span = 1 << $urandom_range(4, 14);
            p.ctr_a = pack3(rand_comp(span), rand_comp(span), rand_comp(span));
            p.ctr_b = pack3(rand_comp(span), rand_comp(span), rand_comp(span));
            p.ext_a = pack3(longint'($urandom_range(span)), longint'($urandom_range(span)),
                            longint'($urandom_range(span)));
            p.ext_b = pack3(longint'($urandom_range(span)), longint'($urandom_range(span)),
                            longint'($urandom_range(span)));
            p.ax = pack3(rand_comp(70000), rand_comp(70000), rand_comp(70000));
            p.ay = pack3(rand_comp(70000), rand_comp(70000), rand_comp(70000));
            p.az = pack3(rand_comp(70000), rand_comp(70000), rand_comp(70000));
            p.bx = pack3(rand_comp(70000), rand_comp(70000), rand_comp(70000));
            p.by = pack3(rand_comp(70000), rand_comp(70000), rand_comp(70000));
            p.bz = pack3(rand_comp(70000), rand_comp(70000), rand_comp(70000));
            if ($urandom_range(9) == 0) p.az = '0;
         end
         send_pair(p);
      end
      finish_sending();
   endtask

   // result checker: every strobe is one transaction
   always @(posedge clock) begin
      bit exp_hit;
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $error("rsp_hit: unexpected transaction, actual %0b", rsp_hit);
            err_count++;
         end else begin
            exp_hit = expected_hits.pop_front();
            if (rsp_hit !== exp_hit) begin
               $error("rsp_hit: expected %0b actual %0b", exp_hit, rsp_hit);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("obb_obb_overlap_test_core_tb failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 34;
      test_random(580);
      send_idle_pct = 76;
      test_random(580);
      send_idle_pct = 0;
      test_random(580);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (err_count == 0 && expected_hits.size() == 0) begin
         $display("obb_obb_overlap_test_core_tb passed");
      end else begin
         $display("obb_obb_overlap_test_core_tb failed");
      end
      $finish;
   end

endmodule
